### hw/rtl/uer_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Phase codes, field widths, range limits and the divide-by-ten constant.
// ---------------------------------------------------------------------------
package uer_pkg;

  // Field and state widths
  localparam int TIMEOUT_W = 20;
  localparam int GAP_W     = 16;
  localparam int TICK_W    = 20;
  localparam int SUM_W     = 23;
  localparam int DIST_W    = 25;
  localparam int PROD_W    = 29;   // count sum times 34
  localparam int QUOT_W    = 26;   // product divided by ten, before the clamp
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 20;
  localparam int S_DATA_W  = 8;
  localparam int M_DATA_W  = 32;

  // Phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TRIG  = 3'd1;
  localparam logic [2:0] PH_RISE  = 3'd2;
  localparam logic [2:0] PH_COUNT = 3'd3;
  localparam logic [2:0] PH_GAP   = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP          = 1'd1;

  // Limits and reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX   = 20'd1000000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd1000000;
  localparam logic [GAP_W-1:0]     GAP_RESET     = 16'd6000;
  localparam logic [DIST_W-1:0]    DIST_MAX      = 25'd17000017;

  // floor(x / 10) = (x * RECIP_10) >> RECIP_SHIFT for any x below 2^32
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          MUL_W       = PROD_W + 32;

  // Per-tick flags carried down the distance pipeline
  typedef struct packed {
    logic trigger;
    logic busy;
    logic done;
  } flags_t;

endpackage

### hw/rtl/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ultrasonic_echo_ranger: trigger/echo range finder with five-shot average
// Sequences trigger pulses, times echo-high intervals and reports distance.
// ---------------------------------------------------------------------------
// Usage:
//   Each request on the s_ side is one 10 us tick carrying the start request
//   and the sampled echo level. Every accepted tick yields exactly one
//   request on the m_ side with the trigger level, busy, done and the last
//   latched distance in hundredths of a centimeter.
//   Throughput is one tick per cycle unless the receiver stalls. A tick
//   passes in order through the phase sequencer, the times-34 stage, the
//   divide-by-ten multiplier and the clamp/output register.
//   s_tready is high whenever the output register is empty or being taken,
//   so a stalled receiver holds the whole pipeline and back-pressures the
//   sender; nothing is dropped.
//   cfg_we writes echo_timeout_ticks (index 0) or gap_ticks (index 1); write
//   only while no run is in progress and the pipeline is drained.
//   Reset (rst, synchronous) returns to idle, clears the sum, the counters
//   and the latched distance, and loads the register defaults.
// ---------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
  parameter int SHOTS = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  // Config write port
  input  logic                              cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_W-1:0]         cfg_data,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: [0] start_req, [1] echo, [7:2] zero
  input  logic [uer_pkg::S_DATA_W-1:0]      s_tdata,
  // Output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: [0] trigger, [1] busy_res, [2] done_res,
  //          [27:3] distance_centi_cm, [31:28] zero
  output logic [uer_pkg::M_DATA_W-1:0]      m_tdata
);

  localparam int SHOT_W = (SHOTS > 1) ? $clog2(SHOTS) : 1;
  localparam logic [SHOT_W-1:0] LAST_SHOT = SHOT_W'(SHOTS - 1);

  // Config registers
  logic [uer_pkg::TIMEOUT_W-1:0] echo_timeout_ticks;
  logic [uer_pkg::GAP_W-1:0]     gap_ticks;

  // Sequencer state
  logic [2:0]                    phase, phase_next;
  logic [uer_pkg::TICK_W-1:0]    tick_count, tick_count_next;
  logic [SHOT_W-1:0]             shot_index, shot_index_next;
  logic [uer_pkg::SUM_W-1:0]     count_sum, count_sum_next;

  // Pipeline registers
  logic                          p1_valid, p2_valid, p3_valid, out_valid;
  uer_pkg::flags_t               p1_flags, p2_flags, p3_flags, out_flags;
  uer_pkg::flags_t               flags_next;
  logic [uer_pkg::SUM_W-1:0]     p1_sum;
  logic [uer_pkg::PROD_W-1:0]    p2_prod;
  logic [uer_pkg::QUOT_W-1:0]    p3_quot;
  logic [uer_pkg::DIST_W-1:0]    distance_reg;

  logic                          advance;
  logic                          in_accept;
  logic                          start_req, echo;
  logic [uer_pkg::TIMEOUT_W-1:0] eff_timeout;
  logic [uer_pkg::TICK_W-1:0]    tick_inc;
  logic                          shot_end, gap_end;
  logic [uer_pkg::MUL_W-1:0]     mul_full;
  logic [uer_pkg::DIST_W-1:0]    dist_clamped;

  assign advance   = !out_valid || m_tready;
  assign s_tready  = advance;
  assign in_accept = s_tvalid && advance;
  assign start_req = s_tdata[0];
  assign echo      = s_tdata[1];

  // Config write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_timeout_ticks <= uer_pkg::TIMEOUT_RESET;
      gap_ticks          <= uer_pkg::GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uer_pkg::REG_ECHO_TIMEOUT: echo_timeout_ticks <= cfg_data;
        uer_pkg::REG_GAP:          gap_ticks <= cfg_data[uer_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_timeout = (echo_timeout_ticks > uer_pkg::TIMEOUT_MAX) ?
                       uer_pkg::TIMEOUT_MAX : echo_timeout_ticks;
  assign tick_inc    = tick_count + uer_pkg::TICK_W'(1);

  // Phase sequencer: next state for one tick
  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    shot_index_next = shot_index;
    count_sum_next  = count_sum;
    flags_next      = '0;
    shot_end        = 1'b0;
    gap_end         = 1'b0;

    unique case (phase)
      uer_pkg::PH_IDLE: begin
        if (start_req) begin
          count_sum_next  = '0;
          shot_index_next = '0;
          tick_count_next = '0;
          phase_next      = uer_pkg::PH_TRIG;
        end
      end
      uer_pkg::PH_TRIG: begin
        flags_next.trigger = 1'b1;
        tick_count_next    = '0;
        phase_next         = uer_pkg::PH_RISE;
      end
      uer_pkg::PH_RISE: begin
        if (echo) begin
          tick_count_next = uer_pkg::TICK_W'(1);
          // only a zero timeout ends the shot on the first echo tick
          if (eff_timeout == '0) shot_end = 1'b1;
          else phase_next = uer_pkg::PH_COUNT;
        end
      end
      uer_pkg::PH_COUNT: begin
        if (echo) begin
          tick_count_next = tick_inc;
          if (tick_inc > eff_timeout) shot_end = 1'b1;
        end else begin
          shot_end = 1'b1;
        end
      end
      uer_pkg::PH_GAP: begin
        tick_count_next = tick_inc;
        if (tick_inc >= uer_pkg::TICK_W'(gap_ticks)) gap_end = 1'b1;
      end
      default: phase_next = uer_pkg::PH_IDLE;
    endcase

    // Shot finished: fold the count into the sum
    if (shot_end) begin
      count_sum_next  = count_sum + uer_pkg::SUM_W'(tick_count_next);
      tick_count_next = '0;
      if (gap_ticks == '0) gap_end = 1'b1;
      else phase_next = uer_pkg::PH_GAP;
    end

    // Gap finished: next shot or end of run
    if (gap_end) begin
      tick_count_next = '0;
      if (shot_index == LAST_SHOT) begin
        flags_next.done = 1'b1;
        phase_next      = uer_pkg::PH_IDLE;
        shot_index_next = '0;
      end else begin
        shot_index_next = shot_index + SHOT_W'(1);
        phase_next      = uer_pkg::PH_TRIG;
      end
    end

    flags_next.busy = (phase_next != uer_pkg::PH_IDLE);
  end

  // Sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= uer_pkg::PH_IDLE;
      tick_count <= '0;
      shot_index <= '0;
      count_sum  <= '0;
    end else if (in_accept) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      shot_index <= shot_index_next;
      count_sum  <= count_sum_next;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      p1_valid  <= s_tvalid;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      out_valid <= p3_valid;
    end
  end

  // Distance datapath: sum*34, then divide by ten through the reciprocal
  assign mul_full = uer_pkg::MUL_W'(p2_prod) * uer_pkg::MUL_W'(uer_pkg::RECIP_10);

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_flags  <= flags_next;
      p1_sum    <= count_sum_next;
      p2_flags  <= p1_flags;
      p2_prod   <= (uer_pkg::PROD_W'(p1_sum) << 5) + (uer_pkg::PROD_W'(p1_sum) << 1);
      p3_flags  <= p2_flags;
      p3_quot   <= mul_full[uer_pkg::RECIP_SHIFT +: uer_pkg::QUOT_W];
      out_flags <= p3_flags;
    end
  end

  assign dist_clamped = (p3_quot > uer_pkg::QUOT_W'(uer_pkg::DIST_MAX)) ?
                        uer_pkg::DIST_MAX : p3_quot[uer_pkg::DIST_W-1:0];

  // Latched distance, updated as the done tick enters the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_reg <= '0;
    end else if (advance && p3_valid && p3_flags.done) begin
      distance_reg <= dist_clamped;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, distance_reg, out_flags.done, out_flags.busy,
                     out_flags.trigger};

  // Assertions
  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_flags.done) |-> !out_flags.busy)
    else $error("done result reported as busy");

  a_trig_not_done : assert property (@(posedge clk) disable iff (rst)
    !(p1_valid && p1_flags.trigger && p1_flags.done))
    else $error("trigger and done on the same tick");

  a_idle_clear : assert property (@(posedge clk) disable iff (rst)
    (phase == uer_pkg::PH_IDLE) |-> (tick_count == '0 && shot_index == '0))
    else $error("idle phase with counters not cleared");

  a_shot_range : assert property (@(posedge clk) disable iff (rst)
    shot_index <= LAST_SHOT)
    else $error("shot index beyond last shot");

endmodule
